### rtl/rlpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlpg_pkg
// Shared types, constants and pattern tables of the rgb led pattern generator.
// ----------------------------------------------------------------------------
package rlpg_pkg;

  localparam int unsigned PatternSteps = 32;
  localparam int unsigned SlotW        = $clog2(PatternSteps);
  localparam int unsigned ChanW        = 8;
  localparam int unsigned DelayW       = 5;
  localparam int unsigned WaveW        = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 8;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    MODE_RAINBOW = 2'd0,
    MODE_SOLID   = 2'd1,
    MODE_PULSE   = 2'd2,
    MODE_OFF     = 2'd3
  } led_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LED_MODE    = 3'd0,
    REG_SPEED_LEVEL = 3'd1,
    REG_BASE_RED    = 3'd2,
    REG_BASE_GREEN  = 3'd3,
    REG_BASE_BLUE   = 3'd4
  } reg_idx_e;

  localparam logic [ChanW-1:0]  ChanMax       = 8'hFF;
  localparam logic [DelayW-1:0] DelayRainbow  = 5'h1C;
  localparam logic [DelayW-1:0] DelayPulse    = 5'h1E;
  localparam logic [DelayW-1:0] DelayStatic   = 5'h10;
  localparam logic [DelayW-1:0] DelayMin      = 5'd4;
  localparam logic [ChanW-1:0]  LoopDelayHold = 8'hFF;

  localparam logic [1:0]       ResetMode  = MODE_RAINBOW;
  localparam logic [2:0]       ResetSpeed = 3'd2;
  localparam logic [ChanW-1:0] ResetRed   = 8'd255;
  localparam logic [ChanW-1:0] ResetGreen = 8'd96;
  localparam logic [ChanW-1:0] ResetBlue  = 8'd160;

  typedef struct packed {
    led_mode_e        mode;
    logic [2:0]       speed;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0]  loop_delay;
    logic              smooth_enable;
    logic [DelayW-1:0] step_delay;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  red;
  } result_t;

  // breathing wave, unsigned q0.16
  function automatic logic [WaveW-1:0] wave_q16(input logic [SlotW-1:0] idx);
    logic [WaveW-1:0] w;
    case (idx)
      5'd0:  w = 16'd39322;
      5'd1:  w = 16'd44599;
      5'd2:  w = 16'd49659;
      5'd3:  w = 16'd54297;
      5'd4:  w = 16'd58322;
      5'd5:  w = 16'd61568;
      5'd6:  w = 16'd63904;
      5'd7:  w = 16'd65234;
      5'd8:  w = 16'd65502;
      5'd9:  w = 16'd64699;
      5'd10: w = 16'd62857;
      5'd11: w = 16'd60051;
      5'd12: w = 16'd56397;
      5'd13: w = 16'd52043;
      5'd14: w = 16'd47169;
      5'd15: w = 16'd41974;
      5'd16: w = 16'd36670;
      5'd17: w = 16'd31474;
      5'd18: w = 16'd26600;
      5'd19: w = 16'd22246;
      5'd20: w = 16'd18592;
      5'd21: w = 16'd15786;
      5'd22: w = 16'd13944;
      5'd23: w = 16'd13141;
      5'd24: w = 16'd13409;
      5'd25: w = 16'd14739;
      5'd26: w = 16'd17075;
      5'd27: w = 16'd20322;
      5'd28: w = 16'd24346;
      5'd29: w = 16'd28984;
      5'd30: w = 16'd34045;
      default: w = 16'd39322;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### rtl/rlpg_color.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlpg_color
// Colour and timing fields of one pattern slot for the current mode.
// ----------------------------------------------------------------------------
module rlpg_color import rlpg_pkg::*; (
  input  var cfg_t             cfg_i,
  input  wire logic [SlotW-1:0] slot_i,
  output var result_t          res_o
);

  localparam int unsigned ScaledW = SlotW + 3;
  localparam int unsigned RampW   = ChanW + SlotW + 1;
  localparam int unsigned ProdW   = ChanW + WaveW;

  logic [ScaledW-1:0] scaled;
  logic [2:0]         sector;
  logic [SlotW-1:0]   rem;
  logic [RampW-1:0]   up_full;
  logic [RampW-1:0]   down_full;
  logic [ChanW-1:0]   up;
  logic [ChanW-1:0]   down;
  logic [ChanW-1:0]   rb_r, rb_g, rb_b;

  logic [WaveW-1:0]   wave;
  logic [ProdW-1:0]   prod_r, prod_g, prod_b;
  logic [ChanW-1:0]   pl_r, pl_g, pl_b;

  logic [DelayW-1:0]  dec;
  logic [DelayW-1:0]  delay_rb;
  logic [DelayW-1:0]  delay_pl;

  // hue sweep: sector and position within it
  assign scaled    = ScaledW'(slot_i) * ScaledW'(6);
  assign sector    = scaled[SlotW +: 3];
  assign rem       = scaled[SlotW-1:0];
  assign up_full   = RampW'(rem) * RampW'(255);
  assign down_full = (RampW'(PatternSteps) - RampW'(rem)) * RampW'(255);
  assign up        = up_full[SlotW +: ChanW];
  assign down      = down_full[SlotW +: ChanW];

  always_comb begin
    case (sector)
      3'd0: begin
        rb_r = ChanMax; rb_g = up;      rb_b = '0;
      end
      3'd1: begin
        rb_r = down;    rb_g = ChanMax; rb_b = '0;
      end
      3'd2: begin
        rb_r = '0;      rb_g = ChanMax; rb_b = up;
      end
      3'd3: begin
        rb_r = '0;      rb_g = down;    rb_b = ChanMax;
      end
      3'd4: begin
        rb_r = up;      rb_g = '0;      rb_b = ChanMax;
      end
      default: begin
        rb_r = ChanMax; rb_g = '0;      rb_b = down;
      end
    endcase
  end

  // breathing scale, truncated to the top bits of the product
  assign wave   = wave_q16(slot_i);
  assign prod_r = ProdW'(cfg_i.red)   * ProdW'(wave);
  assign prod_g = ProdW'(cfg_i.green) * ProdW'(wave);
  assign prod_b = ProdW'(cfg_i.blue)  * ProdW'(wave);
  assign pl_r   = prod_r[WaveW +: ChanW];
  assign pl_g   = prod_g[WaveW +: ChanW];
  assign pl_b   = prod_b[WaveW +: ChanW];

  // step delay from speed, floored at the minimum
  assign dec = {cfg_i.speed, 2'b00};
  assign delay_rb = (dec >= DelayRainbow || (DelayRainbow - dec) < DelayMin) ?
                    DelayMin : DelayRainbow - dec;
  assign delay_pl = (dec >= DelayPulse || (DelayPulse - dec) < DelayMin) ?
                    DelayMin : DelayPulse - dec;

  always_comb begin
    res_o = '0;
    unique case (cfg_i.mode)
      MODE_RAINBOW: begin
        res_o.red        = rb_r;
        res_o.green      = rb_g;
        res_o.blue       = rb_b;
        res_o.step_delay = delay_rb;
      end
      MODE_SOLID: begin
        res_o.red        = cfg_i.red;
        res_o.green      = cfg_i.green;
        res_o.blue       = cfg_i.blue;
        res_o.step_delay = DelayStatic;
        res_o.loop_delay = LoopDelayHold;
      end
      MODE_PULSE: begin
        res_o.red           = pl_r;
        res_o.green         = pl_g;
        res_o.blue          = pl_b;
        res_o.step_delay    = delay_pl;
        res_o.smooth_enable = 1'b1;
      end
      default: begin
        res_o.step_delay = DelayStatic;
        res_o.loop_delay = LoopDelayHold;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/rgb_led_pattern_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_pattern_generator_core
// Per-slot colour and timing generator for a 32-step led pattern.
// ----------------------------------------------------------------------------
// Each transaction on the slave side carries a slot index and yields one
// transaction on the master side with that slot's colour and timing fields.
// A slot is registered on entry, evaluated by table lookup and one multiply
// per channel, and the result registered in the output register; one slot per
// cycle is sustained while the master side is ready. Registers are written
// through the cfg port and should only change while no transaction is in
// flight.
module rgb_led_pattern_generator_core import rlpg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // slave side: tdata[4:0] slot
  input  wire logic                s_axis_tvalid,
  output var  logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // master side: tdata out_red, out_green, out_blue, step_delay,
  // smooth_enable, loop_delay
  output var  logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output var  logic [OutDataW-1:0] m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg_q;
  logic             in_vld_q;
  logic [SlotW-1:0] slot_q;
  logic             out_vld_q;
  result_t          res_q;
  result_t          res_d;
  logic             adv_out;
  logic             adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= led_mode_e'(ResetMode);
      cfg_q.speed <= ResetSpeed;
      cfg_q.red   <= ResetRed;
      cfg_q.green <= ResetGreen;
      cfg_q.blue  <= ResetBlue;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LED_MODE:    cfg_q.mode  <= led_mode_e'(cfg_data_i[1:0]);
        REG_SPEED_LEVEL: cfg_q.speed <= cfg_data_i[2:0];
        REG_BASE_RED:    cfg_q.red   <= cfg_data_i;
        REG_BASE_GREEN:  cfg_q.green <= cfg_data_i;
        REG_BASE_BLUE:   cfg_q.blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv_out       = !out_vld_q || m_axis_tready;
  assign adv_in        = !in_vld_q || adv_out;
  assign s_axis_tready = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid) begin
      slot_q <= s_axis_tdata[SlotW-1:0];
    end
    if (adv_out && in_vld_q) begin
      res_q <= res_d;
    end
  end

  rlpg_color u_color (
    .cfg_i  (cfg_q),
    .slot_i (slot_q),
    .res_o  (res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q};

endmodule
`default_nettype wire
